@@ rtl/qamhd_pkg.sv @@
package qamhd_pkg;

   localparam int unsigned SYMBOL_WIDTH = 8;
   localparam int unsigned AXIS_BITS = 4;
   localparam int unsigned THRESH_WIDTH = 15;
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   typedef enum logic [2:0] {
      MOD_BPSK   = 3'd0,
      MOD_QPSK   = 3'd1,
      MOD_QAM16  = 3'd2,
      MOD_QAM64  = 3'd3,
      MOD_QAM256 = 3'd4
   } modulation_type;

   typedef enum logic [0:0] {
      CSR_MODULATION = 1'b0
   } csr_index_type;

   localparam logic [THRESH_WIDTH-1:0] T16_2   = 15'd10362;
   localparam logic [THRESH_WIDTH-1:0] T64_2   = 15'd5056;
   localparam logic [THRESH_WIDTH-1:0] T64_4   = 15'd10112;
   localparam logic [THRESH_WIDTH-1:0] T64_6   = 15'd15169;
   localparam logic [THRESH_WIDTH-1:0] T256_2  = 15'd2513;
   localparam logic [THRESH_WIDTH-1:0] T256_4  = 15'd5026;
   localparam logic [THRESH_WIDTH-1:0] T256_6  = 15'd7540;
   localparam logic [THRESH_WIDTH-1:0] T256_8  = 15'd10053;
   localparam logic [THRESH_WIDTH-1:0] T256_10 = 15'd12566;
   localparam logic [THRESH_WIDTH-1:0] T256_12 = 15'd15079;
   localparam logic [THRESH_WIDTH-1:0] T256_14 = 15'd17592;

endpackage

@@ rtl/qamhd_axis.sv @@
module qamhd_axis #(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  logic signed [SAMPLE_WIDTH-1:0]         sample,
   input  qamhd_pkg::modulation_type              modulation,
   output logic [qamhd_pkg::AXIS_BITS-1:0]        axis_bits
);

   localparam int unsigned MAG_WIDTH =
      (SAMPLE_WIDTH > qamhd_pkg::THRESH_WIDTH) ? SAMPLE_WIDTH : qamhd_pkg::THRESH_WIDTH;

   logic                    sign_bit;
   logic [SAMPLE_WIDTH-1:0] mag_raw;
   logic [MAG_WIDTH-1:0]    mag;

   assign sign_bit = !sample[SAMPLE_WIDTH-1] && (sample != '0);
   assign mag_raw  = sample[SAMPLE_WIDTH-1] ? (~sample + SAMPLE_WIDTH'(1)) : sample;
   assign mag      = MAG_WIDTH'(mag_raw);

   always_comb begin
      axis_bits    = '0;
      axis_bits[0] = sign_bit;
      case (modulation)
         qamhd_pkg::MOD_QAM16: begin
            axis_bits[1] = mag < MAG_WIDTH'(qamhd_pkg::T16_2);
         end
         qamhd_pkg::MOD_QAM64: begin
            axis_bits[1] = mag < MAG_WIDTH'(qamhd_pkg::T64_4);
            axis_bits[2] = (mag < MAG_WIDTH'(qamhd_pkg::T64_6)) &&
                           (mag > MAG_WIDTH'(qamhd_pkg::T64_2));
         end
         qamhd_pkg::MOD_QAM256: begin
            axis_bits[1] = mag < MAG_WIDTH'(qamhd_pkg::T256_8);
            axis_bits[2] = (mag < MAG_WIDTH'(qamhd_pkg::T256_12)) &&
                           (mag > MAG_WIDTH'(qamhd_pkg::T256_4));
            axis_bits[3] = ((mag < MAG_WIDTH'(qamhd_pkg::T256_6)) &&
                            (mag > MAG_WIDTH'(qamhd_pkg::T256_2))) ||
                           ((mag < MAG_WIDTH'(qamhd_pkg::T256_14)) &&
                            (mag > MAG_WIDTH'(qamhd_pkg::T256_10)));
         end
         default: begin
            axis_bits[3:1] = '0;
         end
      endcase
   end

endmodule

@@ rtl/qam_hard_decision_slicer_unit.sv @@
// Hard-decision QAM slicer. Each transaction on the req_ side carries one equalized sample
// (I and Q, two's complement with 14 fractional bits) and yields one transaction on the rsp_
// side with the decided symbol index for the mode held in the modulation register (address 0):
// 0 BPSK, 1 QPSK, 2 16-QAM, 3 64-QAM, 4 256-QAM; unused codes give zero. The block takes one
// sample per clock cycle while the rsp_ side does not stall. The sample is captured in the
// input register when it is accepted, and the threshold comparisons on it are loaded into the
// result register as soon as that register is free. A stall on the rsp_ side holds both
// registers and, while the input register is full, deasserts req_tready. Write the modulation
// register only while no transaction is in flight.
module qam_hard_decision_slicer_unit #(
   parameter int unsigned SAMPLE_WIDTH = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // Fields from bit 0: sample_i, sample_q, zero padding.
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]        req_tdata,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // Fields from bit 0: symbol_bits.
   output logic [qamhd_pkg::SYMBOL_WIDTH-1:0]         rsp_tdata,
   input  logic                                       csr_psel,
   input  logic                                       csr_penable,
   input  logic                                       csr_pwrite,
   input  logic [qamhd_pkg::CSR_ADDR_WIDTH-1:0]       csr_paddr,
   input  logic [qamhd_pkg::CSR_DATA_WIDTH-1:0]       csr_pwdata,
   output logic [qamhd_pkg::CSR_DATA_WIDTH-1:0]       csr_prdata,
   output logic                                       csr_pready
);

   localparam int unsigned AB = qamhd_pkg::AXIS_BITS;

   qamhd_pkg::modulation_type              mode_ff;
   qamhd_pkg::modulation_type              mode_in;
   logic                                   csr_write;
   logic                                   csr_hit;

   logic                                   s1_valid_ff;
   logic                                   s1_valid_in;
   logic signed [SAMPLE_WIDTH-1:0]         s1_i_ff;
   logic signed [SAMPLE_WIDTH-1:0]         s1_q_ff;
   logic                                   s2_ready;
   logic                                   s1_load;

   logic                                   rsp_valid_ff;
   logic                                   rsp_valid_in;
   logic [qamhd_pkg::SYMBOL_WIDTH-1:0]     rsp_data_ff;
   logic [qamhd_pkg::SYMBOL_WIDTH-1:0]     rsp_data_in;

   logic [AB-1:0]                          bits_i;
   logic [AB-1:0]                          bits_q;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[qamhd_pkg::CSR_ADDR_WIDTH-1:2] ==
                       (qamhd_pkg::CSR_ADDR_WIDTH-2)'(qamhd_pkg::CSR_MODULATION);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign mode_in    = (csr_write && csr_hit) ?
                       qamhd_pkg::modulation_type'(csr_pwdata[2:0]) : mode_ff;
   assign csr_prdata = csr_hit ? qamhd_pkg::CSR_DATA_WIDTH'(mode_ff) : '0;

   assign s2_ready    = !rsp_valid_ff || rsp_tready;
   assign req_tready  = !s1_valid_ff || s2_ready;
   assign s1_load     = req_tvalid && req_tready;
   assign s1_valid_in = s1_load || (s1_valid_ff && !s2_ready);
   assign rsp_valid_in = s1_valid_ff || (rsp_valid_ff && !rsp_tready);

   qamhd_axis #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_axis_i (
      .sample     (s1_i_ff),
      .modulation (mode_ff),
      .axis_bits  (bits_i)
   );

   qamhd_axis #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_axis_q (
      .sample     (s1_q_ff),
      .modulation (mode_ff),
      .axis_bits  (bits_q)
   );

   always_comb begin
      rsp_data_in = '0;
      case (mode_ff)
         qamhd_pkg::MOD_BPSK: begin
            rsp_data_in[0] = bits_i[0];
         end
         qamhd_pkg::MOD_QPSK: begin
            rsp_data_in[1:0] = {bits_q[0], bits_i[0]};
         end
         qamhd_pkg::MOD_QAM16: begin
            rsp_data_in[3:0] = {bits_q[1:0], bits_i[1:0]};
         end
         qamhd_pkg::MOD_QAM64: begin
            rsp_data_in[5:0] = {bits_q[2:0], bits_i[2:0]};
         end
         qamhd_pkg::MOD_QAM256: begin
            rsp_data_in = {bits_q, bits_i};
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= qamhd_pkg::MOD_BPSK;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_i_ff <= req_tdata[SAMPLE_WIDTH-1:0];
         s1_q_ff <= req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
      end
      if (s1_valid_ff && s2_ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_stage_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_ready |=> rsp_valid_ff)
      else $error("Input register item did not reach the result register.");

   a_stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_i_ff) && $stable(s1_q_ff))
      else $error("Stalled item in the input register was lost or changed.");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && rsp_valid_ff && !rsp_tready)
      else $error("Input stalled while the pipeline had room.");

   a_unused_bits: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s2_ready && (mode_ff == qamhd_pkg::MOD_BPSK) |=> rsp_tdata[7:1] == '0)
      else $error("BPSK result has upper bits set.");
`endif

endmodule
